FILE: rtl/smp_pkg.sv
`timescale 1ns / 1ps

package smp_pkg;

  localparam int DATA_W   = 32;
  localparam int POW_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int SIZE_DEF = 4;

  // 1.0 in Q16.16
  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // control that travels with one multiply-accumulate term
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage

FILE: rtl/smp_mac.sv
`timescale 1ns / 1ps

module smp_mac import smp_pkg::*; #(
  parameter int SIZE = SIZE_DEF,
  parameter int IW   = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  input  tag_t                     tag_i,
  input  logic [IW-1:0]            dest_i,
  output logic                     busy_o,
  output logic                     wr_en_o,
  output logic [IW-1:0]            wr_idx_o,
  output logic [DATA_W-1:0]        wr_data_o
);

  localparam int CW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int PW = 2 * DATA_W;
  localparam int AW = PW + CW;
  localparam int SW = AW - FRAC_W;

  localparam logic [DATA_W-1:0] MAX_Q = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_Q = {1'b1, {(DATA_W-1){1'b0}}};

  tag_t                 tag2_q, tag3_q;
  logic signed [PW-1:0] p_q;
  logic [IW-1:0]        dest2_q, dest3_q;
  logic signed [AW-1:0] acc_q, acc_d, p_ext;
  logic [SW-1:0]        sh;
  logic [SW-DATA_W:0]   top;
  logic                 ovf;

  // stage 2: product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag2_q <= tag_i;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= a_i * b_i;
    dest2_q <= dest_i;
    if (tag2_q.valid) begin
      acc_q   <= acc_d;
      dest3_q <= dest2_q;
    end
  end

  // stage 3: exact accumulate
  always_comb begin
    p_ext = {{CW{p_q[PW-1]}}, p_q};
    acc_d = tag2_q.first ? p_ext : acc_q + p_ext;
  end

  // floor shift, then saturate when the sign bit and the bits above it disagree
  always_comb begin
    sh        = acc_q[AW-1:FRAC_W];
    top       = sh[SW-1:DATA_W-1];
    ovf       = !(&top) && (|top);
    wr_data_o = ovf ? (sh[SW-1] ? MIN_Q : MAX_Q) : sh[DATA_W-1:0];
  end

  assign wr_en_o  = tag3_q.valid && tag3_q.last;
  assign wr_idx_o = dest3_q;
  assign busy_o   = tag2_q.valid || tag3_q.valid;

endmodule

FILE: rtl/square_matrix_power_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   element_i, power_i, last_i
// out       out  out_valid_o/out_ready_i result_o, final_res_o
//
// Loading: one element per cycle while in_ready_o is high. The request with
//   last_i set starts work. Compute: power_i steps on the one shared 32x32
//   multiplier, fed from the source and product memories.
// Unloading: SIZE*SIZE results, one per cycle while out_ready_i is high.
// Reset clears control only; memories are not cleared.
// A stalled result holds in the output register; the next matrix may load
//   while results drain, and its start waits until unloading ends. Input
//   pauses in the cycle in which unloading ends.

module square_matrix_power_unit import smp_pkg::*; #(
  parameter int SIZE = SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] element_i,
  input  logic [POW_W-1:0]         power_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] result_o,
  output logic                     final_res_o
);

  localparam int CELLS  = SIZE * SIZE;
  localparam int IW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW     = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CNTW   = $clog2(CELLS + 1);
  localparam int PDEPTH = 2 * CELLS;
  localparam int PAW    = $clog2(PDEPTH);

  // ---------------- control state ----------------
  state_e            state_q, state_d;
  logic [CNTW-1:0]   load_cnt_q;
  logic [POW_W-1:0]  pow_left_q;
  logic              pend_q;      // start request taken during unload
  logic              ident_q;     // running product is the identity
  logic              cur_q;       // bank of the running product
  logic [CW-1:0]     i_q, j_q, r_q;
  logic [CW-1:0]     orow_q, ocol_q;
  logic              odone_q;

  // ---------------- memories ----------------
  logic [DATA_W-1:0] src_mem  [CELLS];
  logic [DATA_W-1:0] prod_mem [PDEPTH];
  logic [DATA_W-1:0] src_rdata_q, prod_rdata_q;

  // ---------------- stage 1 (memory read) ----------------
  tag_t              s1_tag_q;
  logic              s1_diag_q;
  logic [IW-1:0]     s1_dest_q;

  // ---------------- output side ----------------
  logic              rd_pend_q, rd_ident_q, rd_diag_q, rd_final_q;
  logic              out_valid_q, final_q;
  logic [DATA_W-1:0] result_q;

  // ---------------- decode ----------------
  logic              in_fire, start_now, calc_issue, out_issue, consume;
  logic              last_term, step_end, drain_done, out_exit, kick, enter_out;
  logic              prod_re;
  logic [IW-1:0]     idx_a, idx_b, idx_dst, idx_out, src_widx;
  logic [PAW-1:0]    prod_raddr, prod_waddr;
  logic signed [DATA_W-1:0] mac_a;

  logic              mac_busy, mac_wr_en;
  logic [IW-1:0]     mac_wr_idx;
  logic [DATA_W-1:0] mac_wr_data;

  assign in_fire    = in_valid_i && in_ready_o;
  assign last_term  = (r_q == CW'(SIZE - 1));
  assign step_end   = last_term && (j_q == CW'(SIZE - 1)) && (i_q == CW'(SIZE - 1));
  assign drain_done = !s1_tag_q.valid && !mac_busy;
  assign consume    = rd_pend_q && (!out_valid_q || out_ready_i);
  assign out_exit   = (state_q == ST_OUT) && odone_q && !rd_pend_q;
  assign start_now  = in_fire && last_i && (state_q == ST_LOAD);
  assign kick       = start_now || (out_exit && pend_q);
  assign enter_out  = (state_d == ST_OUT) && ((state_q != ST_OUT) || out_exit);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start_now) begin
          state_d = (power_i == '0) ? ST_OUT : ST_CALC;
        end
      end
      ST_CALC: begin
        if (step_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_d = (pow_left_q == POW_W'(1)) ? ST_OUT : ST_CALC;
        end
      end
      ST_OUT: begin
        if (out_exit) begin
          if (pend_q) begin
            state_d = (pow_left_q == '0) ? ST_OUT : ST_CALC;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    calc_issue = 1'b0;
    out_issue  = 1'b0;
    unique case (state_q)
      ST_LOAD:  in_ready_o = 1'b1;
      ST_CALC:  calc_issue = 1'b1;
      ST_DRAIN: ;
      ST_OUT: begin
        // closed in the exit cycle: a start there would miss the hand-off
        in_ready_o = !pend_q && !out_exit;
        out_issue  = !odone_q && (!rd_pend_q || consume);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- loading ----------------
  assign src_widx = load_cnt_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      pow_left_q <= '0;
      pend_q     <= 1'b0;
      ident_q    <= 1'b0;
      cur_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        if (last_i) begin
          load_cnt_q <= '0;
          pow_left_q <= power_i;
        end else if (load_cnt_q < CNTW'(CELLS)) begin
          load_cnt_q <= load_cnt_q + CNTW'(1);
        end
      end
      if (in_fire && last_i && (state_q == ST_OUT)) begin
        pend_q <= 1'b1;
      end else if (out_exit) begin
        pend_q <= 1'b0;
      end
      if (kick) begin
        ident_q <= 1'b1;
      end else if ((state_q == ST_DRAIN) && drain_done) begin
        ident_q    <= 1'b0;
        cur_q      <= !cur_q;
        pow_left_q <= pow_left_q - POW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (load_cnt_q < CNTW'(CELLS))) begin
      src_mem[src_widx] <= element_i;
    end
  end

  // ---------------- compute sequencer: row i, column j, term r ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      r_q <= '0;
    end else if (calc_issue) begin
      if (last_term) begin
        r_q <= '0;
        if (j_q == CW'(SIZE - 1)) begin
          j_q <= '0;
          i_q <= (i_q == CW'(SIZE - 1)) ? '0 : i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end else begin
        r_q <= r_q + CW'(1);
      end
    end
  end

  assign idx_a   = IW'(int'(i_q) * SIZE + int'(r_q));
  assign idx_b   = IW'(int'(r_q) * SIZE + int'(j_q));
  assign idx_dst = IW'(int'(i_q) * SIZE + int'(j_q));
  assign idx_out = IW'(int'(orow_q) * SIZE + int'(ocol_q));

  // product memory holds two banks: running product and the one being formed
  always_comb begin
    prod_raddr = cur_q ? PAW'(CELLS) + PAW'(calc_issue ? idx_a : idx_out)
                       : PAW'(calc_issue ? idx_a : idx_out);
    prod_waddr = cur_q ? PAW'(mac_wr_idx) : PAW'(CELLS) + PAW'(mac_wr_idx);
  end

  assign prod_re = calc_issue || out_issue;

  always_ff @(posedge clk_i) begin
    if (calc_issue) begin
      src_rdata_q <= src_mem[idx_b];
    end
    if (prod_re) begin
      prod_rdata_q <= prod_mem[prod_raddr];
    end
    if (mac_wr_en) begin
      prod_mem[prod_waddr] <= mac_wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else begin
      s1_tag_q.valid <= calc_issue;
      s1_tag_q.first <= (r_q == '0);
      s1_tag_q.last  <= last_term;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_diag_q <= (i_q == r_q);
    s1_dest_q <= idx_dst;
  end

  // first step multiplies the identity, which is never stored
  assign mac_a = ident_q ? (s1_diag_q ? ONE_Q : '0) : prod_rdata_q;

  smp_mac #(
    .SIZE (SIZE),
    .IW   (IW)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .a_i       (mac_a),
    .b_i       (src_rdata_q),
    .tag_i     (s1_tag_q),
    .dest_i    (s1_dest_q),
    .busy_o    (mac_busy),
    .wr_en_o   (mac_wr_en),
    .wr_idx_o  (mac_wr_idx),
    .wr_data_o (mac_wr_data)
  );

  // ---------------- unloading ----------------
  // Read data stays in the memory output register until the output
  // register can take it, so no skid buffer is needed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orow_q      <= '0;
      ocol_q      <= '0;
      odone_q     <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (enter_out) begin
        orow_q  <= '0;
        ocol_q  <= '0;
        odone_q <= 1'b0;
      end else if (out_issue) begin
        if (ocol_q == CW'(SIZE - 1)) begin
          ocol_q <= '0;
          if (orow_q == CW'(SIZE - 1)) begin
            odone_q <= 1'b1;
          end else begin
            orow_q <= orow_q + CW'(1);
          end
        end else begin
          ocol_q <= ocol_q + CW'(1);
        end
      end
      if (out_issue) begin
        rd_pend_q <= 1'b1;
      end else if (consume) begin
        rd_pend_q <= 1'b0;
      end
      if (consume) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_issue) begin
      rd_ident_q <= ident_q;
      rd_diag_q  <= (orow_q == ocol_q);
      rd_final_q <= (orow_q == CW'(SIZE - 1)) && (ocol_q == CW'(SIZE - 1));
    end
    if (consume) begin
      result_q <= rd_ident_q ? (rd_diag_q ? ONE_Q : '0) : prod_rdata_q;
      final_q  <= rd_final_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign final_res_o = final_q;

  // ---------------- assertions ----------------
  a_wr_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_wr_en |-> (state_q == ST_CALC || state_q == ST_DRAIN))
    else $error("product write outside compute");

  a_no_load_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> !in_ready_o)
    else $error("input ready while computing");

  a_load_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CNTW'(CELLS))
    else $error("load count past matrix size");

  a_drained_before_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d == ST_OUT) |-> (!s1_tag_q.valid && !mac_busy))
    else $error("unload started with terms in flight");

endmodule
